### src/pkf_pkg.sv
package pkf_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int VarWidth  = DataWidth - 1;
  localparam int StepWidth = 16;
  localparam int CordicSteps = 30;
  localparam int StepIdxW  = 5;

  localparam logic [31:0] InvTwoPiQ32  = 32'd683565276;
  localparam logic [31:0] CordicGainQ30 = 32'd652032874;

  localparam logic [StepWidth-1:0] StepTimeReset = 16'd3277;
  localparam logic [VarWidth-1:0]  ProcPosReset  = 31'd6554;
  localparam logic [VarWidth-1:0]  ProcHeadReset = 31'd13107;
  localparam logic [VarWidth-1:0]  MeasPosReset  = 31'd13107;
  localparam logic [VarWidth-1:0]  MeasHeadReset = 31'd13107;
  localparam logic [DataWidth-1:0] VarReset      = 32'd65536;

  localparam logic [2:0] RegStepTime  = 3'd0;
  localparam logic [2:0] RegProcPos   = 3'd1;
  localparam logic [2:0] RegProcHead  = 3'd2;
  localparam logic [2:0] RegMeasPos   = 3'd3;
  localparam logic [2:0] RegMeasHead  = 3'd4;

  localparam logic CmdPredict = 1'b0;
  localparam logic CmdCorrect = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PHASE,
    S_CORDIC,
    S_PRED_DV,
    S_PRED_DX,
    S_PRED_DY,
    S_PRED_DH,
    S_COR_SETUP,
    S_COR_DIV,
    S_COR_EST,
    S_COR_VAR,
    S_OUT
  } state_t;

  function automatic logic [CordicSteps*32-1:0] atan_rom();
    atan_rom = {32'd1, 32'd3, 32'd5, 32'd10, 32'd20, 32'd41, 32'd81, 32'd163,
                32'd326, 32'd652, 32'd1303, 32'd2607, 32'd5214, 32'd10428,
                32'd20856, 32'd41711, 32'd83422, 32'd166843, 32'd333687,
                32'd667373, 32'd1334743, 32'd2669480, 32'd5338882,
                32'd10677218, 32'd21349465, 32'd42667331, 32'd85004756,
                32'd167458907, 32'd316933406, 32'd536870912};
  endfunction

  function automatic logic signed [33:0] atan_turn(input logic [StepIdxW-1:0] i);
    logic [CordicSteps*32-1:0] t;
    t = atan_rom();
    atan_turn = $signed({2'b00, t[i*32 +: 32]});
  endfunction

endpackage

### src/pkf_if.sv
interface pkf_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [31:0] speed;
  logic signed [31:0] turn_rate;
  logic signed [31:0] meas_x;
  logic signed [31:0] meas_y;
  logic signed [31:0] meas_heading;
  modport source(output valid, cmd, speed, turn_rate, meas_x, meas_y, meas_heading,
                 input ready);
  modport sink(input valid, cmd, speed, turn_rate, meas_x, meas_y, meas_heading,
               output ready);
endinterface

interface pkf_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] est_x;
  logic signed [31:0] est_y;
  logic signed [31:0] est_heading;
  logic [30:0] out_var_x;
  logic [30:0] out_var_y;
  logic [30:0] out_var_heading;
  modport source(output valid, est_x, est_y, est_heading, out_var_x, out_var_y,
                 out_var_heading, input ready);
  modport sink(input valid, est_x, est_y, est_heading, out_var_x, out_var_y,
               out_var_heading, output ready);
endinterface

### src/pose_kalman_filter_core.sv
// Planar pose Kalman filter: pose (x, y, heading), signed Q16.16, and
// per-axis variances, unsigned Q16.16.
// Channels: in (pkf_in_if sink) takes one item per command; cmd 0 predicts
// from speed and turn rate, cmd 1 corrects with a position/heading fix.
// out (pkf_out_if source) returns one item per input: the state after it.
// Config: APB-style port, five registers at byte addresses 0,4,..,16.
// Datapath: one shared 34x34 signed multiplier under a sequencer.
// Predict: 1 phase step, 30 CORDIC steps, 4 multiply steps and the output
// step. Correct: per axis 1 setup step, 49 divide steps (restoring, one
// quotient bit a cycle) and 2 multiply steps, for three axes, then the
// output step. The divider loop sets the correct-item latency.
// in.ready is high only in idle; one item is in flight at a time.
// The result sits in an output register; if the receiver stalls, the
// block holds it and the next item is accepted from the cycle after it
// has been taken.
// Reset (rst, synchronous): pose cleared, variances 1.0, registers to
// their defaults, output empty.
module pose_kalman_filter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  pkf_in_if.sink      in,
  pkf_out_if.source   out
);

  localparam int DW = pkf_pkg::DataWidth;
  localparam int FB = pkf_pkg::FracBits;

  // configuration
  logic [pkf_pkg::StepWidth-1:0] step_time;
  logic [pkf_pkg::VarWidth-1:0]  proc_pos, proc_head, meas_pos, meas_head;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= pkf_pkg::StepTimeReset;
      proc_pos  <= pkf_pkg::ProcPosReset;
      proc_head <= pkf_pkg::ProcHeadReset;
      meas_pos  <= pkf_pkg::MeasPosReset;
      meas_head <= pkf_pkg::MeasHeadReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        pkf_pkg::RegStepTime: step_time <= pwdata[15:0];
        pkf_pkg::RegProcPos:  proc_pos  <= pwdata[30:0];
        pkf_pkg::RegProcHead: proc_head <= pwdata[30:0];
        pkf_pkg::RegMeasPos:  meas_pos  <= pwdata[30:0];
        pkf_pkg::RegMeasHead: meas_head <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pkf_pkg::RegStepTime: prdata = {16'd0, step_time};
      pkf_pkg::RegProcPos:  prdata = {1'b0, proc_pos};
      pkf_pkg::RegProcHead: prdata = {1'b0, proc_head};
      pkf_pkg::RegMeasPos:  prdata = {1'b0, meas_pos};
      pkf_pkg::RegMeasHead: prdata = {1'b0, meas_head};
      default:              prdata = '0;
    endcase
  end

  // filter state
  logic signed [DW-1:0] pos_x, pos_y, heading;
  logic [DW-1:0] var_x, var_y, var_heading;

  // latched item
  logic signed [DW-1:0] a_in, b_in, mx, my, mh;

  // working registers
  pkf_pkg::state_t state, state_next;
  logic [4:0]  step;       // cordic step / loop counter
  logic [5:0]  div_cnt;
  logic [1:0]  axis;
  logic        flip;
  logic signed [33:0] cx, cy, cz;
  logic signed [63:0] acc;  // held gain*innovation product
  logic signed [DW-1:0] dv;
  // divider
  logic [48:0] rem;
  logic [48:0] num;
  logic [32:0] den;
  logic [16:0] gain;

  function automatic logic signed [DW-1:0] sat_est(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat_est = 32'h7fffffff;
    else if (v < -66'sd2147483648) sat_est = 32'h80000000;
    else sat_est = v[31:0];
  endfunction

  function automatic logic [DW-1:0] sat_var(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat_var = 32'h7fffffff;
    else if (v < 66'sd0) sat_var = '0;
    else sat_var = v[31:0];
  endfunction

  // axis selection for correct
  logic signed [DW-1:0] ax_est, ax_meas;
  logic [DW-1:0] ax_var;
  logic [pkf_pkg::VarWidth-1:0] ax_noise;
  always_comb begin
    case (axis)
      2'd0: begin ax_est = pos_x; ax_var = var_x; ax_meas = mx; ax_noise = meas_pos; end
      2'd1: begin ax_est = pos_y; ax_var = var_y; ax_meas = my; ax_noise = meas_pos; end
      default: begin
        ax_est = heading; ax_var = var_heading; ax_meas = mh; ax_noise = meas_head;
      end
    endcase
  end

  // shared multiplier: one 34x34 signed product per cycle
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] mul_p;
  logic signed [33:0] dts;
  assign dts = $signed({18'd0, step_time});
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      pkf_pkg::S_PHASE: begin
        mul_a = 34'(heading);
        mul_b = $signed({2'b00, pkf_pkg::InvTwoPiQ32});
      end
      pkf_pkg::S_PRED_DV: begin mul_a = dts; mul_b = 34'(a_in); end
      pkf_pkg::S_PRED_DX: begin mul_a = 34'(dv); mul_b = flip ? -cx : cx; end
      pkf_pkg::S_PRED_DY: begin mul_a = 34'(dv); mul_b = flip ? -cy : cy; end
      pkf_pkg::S_PRED_DH: begin mul_a = dts; mul_b = 34'(b_in); end
      pkf_pkg::S_COR_EST: begin
        mul_a = $signed({17'd0, num[16:0]});
        mul_b = 34'(ax_meas) - 34'(ax_est);
      end
      pkf_pkg::S_COR_VAR: begin
        mul_a = $signed({2'b00, ax_var});
        mul_b = 34'sd65536 - $signed({17'd0, gain});
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // phase from heading: low bits of heading * 2^32/(2*pi), in turns
  logic [31:0] ph, ph_r;
  logic ph_flip;
  assign ph = mul_p[FB +: 32];
  assign ph_flip = (ph + 32'h40000000) >= 32'h80000000;
  assign ph_r = ph_flip ? ph + 32'h80000000 : ph;

  // cordic step
  logic signed [33:0] xs, ys, at;
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign at = pkf_pkg::atan_turn(step);

  // divider step
  logic [49:0] trial;
  assign trial = {rem[47:0], num[48]} - {17'd0, den};

  logic signed [65:0] rnd16, rnd30;
  assign rnd16 = 66'(mul_p + 68'sd32768) >>> 16;
  assign rnd30 = 66'((mul_p + 68'sd536870912) >>> 30);

  // estimate correction held from the gain*innovation cycle
  logic signed [65:0] rnd16_e;
  always_ff @(posedge clk) begin
    if (state == pkf_pkg::S_COR_EST) acc <= mul_p[63:0];
  end
  assign rnd16_e = 66'(acc + 64'sd32768) >>> 16;

  logic in_fire, out_fire;
  assign in_fire  = in.valid && in.ready;
  assign out_fire = out.valid && out.ready;
  assign in.ready = (state == pkf_pkg::S_IDLE) && !out.valid;

  always_comb begin
    state_next = state;
    case (state)
      pkf_pkg::S_IDLE:
        if (in_fire) state_next = in.cmd == pkf_pkg::CmdPredict ?
                                  pkf_pkg::S_PHASE : pkf_pkg::S_COR_SETUP;
      pkf_pkg::S_PHASE:   state_next = pkf_pkg::S_CORDIC;
      pkf_pkg::S_CORDIC:  if (step == 5'(pkf_pkg::CordicSteps - 1))
                            state_next = pkf_pkg::S_PRED_DV;
      pkf_pkg::S_PRED_DV: state_next = pkf_pkg::S_PRED_DX;
      pkf_pkg::S_PRED_DX: state_next = pkf_pkg::S_PRED_DY;
      pkf_pkg::S_PRED_DY: state_next = pkf_pkg::S_PRED_DH;
      pkf_pkg::S_PRED_DH: state_next = pkf_pkg::S_OUT;
      pkf_pkg::S_COR_SETUP: state_next = pkf_pkg::S_COR_DIV;
      pkf_pkg::S_COR_DIV: if (div_cnt == 6'd48) state_next = pkf_pkg::S_COR_EST;
      pkf_pkg::S_COR_EST: state_next = pkf_pkg::S_COR_VAR;
      pkf_pkg::S_COR_VAR: state_next = axis == 2'd2 ? pkf_pkg::S_OUT
                                                    : pkf_pkg::S_COR_SETUP;
      pkf_pkg::S_OUT:     state_next = pkf_pkg::S_IDLE;
      default:            state_next = pkf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pkf_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0; pos_y <= '0; heading <= '0;
      var_x <= pkf_pkg::VarReset; var_y <= pkf_pkg::VarReset;
      var_heading <= pkf_pkg::VarReset;
      out.valid <= 1'b0;
      step <= '0; div_cnt <= '0; axis <= '0;
    end else begin
      if (out_fire) out.valid <= 1'b0;
      case (state)
        pkf_pkg::S_IDLE: if (in_fire) begin
          a_in <= in.speed; b_in <= in.turn_rate;
          mx <= in.meas_x; my <= in.meas_y; mh <= in.meas_heading;
          axis <= '0;
        end
        pkf_pkg::S_PHASE: begin
          flip <= ph_flip;
          cx <= $signed({2'b00, pkf_pkg::CordicGainQ30});
          cy <= '0;
          cz <= 34'($signed(ph_r));
          step <= '0;
        end
        pkf_pkg::S_CORDIC: begin
          if (!cz[33]) begin cx <= cx - ys; cy <= cy + xs; cz <= cz - at; end
          else begin cx <= cx + ys; cy <= cy - xs; cz <= cz + at; end
          step <= step + 5'd1;
        end
        pkf_pkg::S_PRED_DV: dv <= rnd16[31:0];
        pkf_pkg::S_PRED_DX: pos_x <= sat_est(66'(pos_x) + rnd30);
        pkf_pkg::S_PRED_DY: pos_y <= sat_est(66'(pos_y) + rnd30);
        pkf_pkg::S_PRED_DH: begin
          heading <= sat_est(66'(heading) + rnd16);
          var_x <= sat_var(66'(var_x) + 66'(proc_pos));
          var_y <= sat_var(66'(var_y) + 66'(proc_pos));
          var_heading <= sat_var(66'(var_heading) + 66'(proc_head));
        end
        pkf_pkg::S_COR_SETUP: begin
          den <= {1'b0, ax_var} + {2'b00, ax_noise};
          num <= {1'b0, ax_var, 16'd0} + 49'({1'b0, ax_var} + {2'b00, ax_noise}) / 2;
          rem <= '0;
          div_cnt <= '0;
          gain <= '0;
        end
        pkf_pkg::S_COR_DIV: begin
          if (!trial[49]) rem <= trial[48:0];
          else rem <= {rem[47:0], num[48]};
          num <= {num[47:0], !trial[49]};
          div_cnt <= div_cnt + 6'd1;
        end
        pkf_pkg::S_COR_EST: begin
          gain <= num[16:0];
          // quotient is at most 65536 since var <= den
        end
        pkf_pkg::S_COR_VAR: begin
          if (den != '0) begin
            case (axis)
              2'd0: begin
                pos_x <= sat_est(66'(pos_x) + rnd16_e);
                var_x <= sat_var(rnd16);
              end
              2'd1: begin
                pos_y <= sat_est(66'(pos_y) + rnd16_e);
                var_y <= sat_var(rnd16);
              end
              default: begin
                heading <= sat_est(66'(heading) + rnd16_e);
                var_heading <= sat_var(rnd16);
              end
            endcase
          end
          axis <= axis + 2'd1;
        end
        pkf_pkg::S_OUT: out.valid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out.est_x = pos_x;
  assign out.est_y = pos_y;
  assign out.est_heading = heading;
  assign out.out_var_x = var_x[30:0];
  assign out.out_var_y = var_y[30:0];
  assign out.out_var_heading = var_heading[30:0];

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> state == pkf_pkg::S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in.ready) else $error("accepted while busy");
`endif

endmodule
